### hdl/aes_cbc_pkg.sv
// Shared types, register indexes and AES byte functions for the AES-256 CBC engine.
package aes_cbc_pkg;

	localparam int NUM_RK = 15;
	localparam int LAST_ROUND = 14;
	localparam int BLK_BYTES = 16;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_IV_HI = 3'd4;
	localparam logic [2:0] REG_IV_LO = 3'd5;
	localparam logic [2:0] REG_DEC = 3'd6;

	localparam logic [2047:0] SBOX_TBL = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16};

	localparam logic [2047:0] INV_SBOX_TBL = {
		128'h52096ad53036a538bf40a39e81f3d7fb,
		128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e,
		128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692,
		128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506,
		128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673,
		128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b,
		128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f,
		128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961,
		128'h172b047eba77d626e169146355210c7d};

	typedef struct packed {
		logic       kx_load;
		logic       kx_step;
		logic       blk_load;
		logic       rnd_en;
		logic [3:0] cnt;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic key_wr;
	} dp_sts_t;

	function automatic logic [7:0] sb(input logic [7:0] x);
		return SBOX_TBL[{~x, 3'b111} -: 8];
	endfunction

	function automatic logic [7:0] isb(input logic [7:0] x);
		return INV_SBOX_TBL[{~x, 3'b111} -: 8];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] k);
		logic [7:0] r;
		case (k)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// byte 0 is the most significant byte
	function automatic logic [127:0] sub_bytes(input logic [127:0] v, input logic inv);
		logic [127:0] t;
		for (int i = 0; i < BLK_BYTES; i++) begin
			t[127-8*i -: 8] = inv ? isb(v[127-8*i -: 8]) : sb(v[127-8*i -: 8]);
		end
		return t;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] v, input logic inv);
		logic [127:0] t;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inv) begin
					t[127-8*(r+4*((c+r)&3)) -: 8] = v[127-8*(r+4*c) -: 8];
				end else begin
					t[127-8*(r+4*c) -: 8] = v[127-8*(r+4*((c+r)&3)) -: 8];
				end
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] v, input logic inv);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m3 [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				a[i] = v[127-8*(4*c+i) -: 8];
				x2[i] = xt(a[i]);
				x4[i] = xt(x2[i]);
				x8[i] = xt(x4[i]);
				m3[i] = x2[i] ^ a[i];
				m9[i] = x8[i] ^ a[i];
				m11[i] = x8[i] ^ x2[i] ^ a[i];
				m13[i] = x8[i] ^ x4[i] ^ a[i];
				m14[i] = x8[i] ^ x4[i] ^ x2[i];
			end
			if (inv) begin
				t[127-8*(4*c) -: 8]   = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
				t[127-8*(4*c+1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
				t[127-8*(4*c+2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
				t[127-8*(4*c+3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
			end else begin
				t[127-8*(4*c) -: 8]   = x2[0] ^ m3[1] ^ a[2] ^ a[3];
				t[127-8*(4*c+1) -: 8] = a[0] ^ x2[1] ^ m3[2] ^ a[3];
				t[127-8*(4*c+2) -: 8] = a[0] ^ a[1] ^ x2[2] ^ m3[3];
				t[127-8*(4*c+3) -: 8] = m3[0] ^ a[1] ^ a[2] ^ x2[3];
			end
		end
		return t;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
	endfunction

	// next round key from the last eight expanded words
	function automatic logic [127:0] kx_next(input logic [255:0] kx, input logic [3:0] idx);
		logic [31:0] t;
		logic [31:0] n0;
		logic [31:0] n1;
		logic [31:0] n2;
		logic [31:0] n3;
		logic [3:0] k;
		k = {1'b0, idx[3:1]} - 4'd1;
		if (!idx[0]) begin
			t = sub_word({kx[23:0], kx[31:24]}) ^ {rcon(k), 24'h0};
		end else begin
			t = sub_word(kx[31:0]);
		end
		n0 = kx[255:224] ^ t;
		n1 = kx[223:192] ^ n0;
		n2 = kx[191:160] ^ n1;
		n3 = kx[159:128] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

endpackage

### hdl/aes256_cbc_block_engine.sv
// An accepted input transaction runs the 14 rounds, then the output load sets out_valid;
// the load waits while out_stall holds the output register. A new block is taken only
// once the one before it has been loaded into the output register. A key write re-expands
// the schedule (key load, then 13 round keys, one per cycle); input stalls then.
// Reset: asynchronous, active low; clears config registers, chain and control, then the
// zero key is expanded before the first transaction is taken.
module aes256_cbc_block_engine import aes_cbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        first_block,
	input  logic        last_block,
	input  logic [4:0]  valid_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic        out_last,
	output logic        pad_removed
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	aes_cbc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts(sts),
		.cmd(cmd)
	);

	aes_cbc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.block_high(block_high),
		.block_low(block_low),
		.first_block(first_block),
		.last_block(last_block),
		.valid_bytes(valid_bytes),
		.out_high(out_high),
		.out_low(out_low),
		.out_last(out_last),
		.pad_removed(pad_removed),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

### hdl/aes_cbc_ctrl.sv
// Sequencer for key expansion, AES rounds and the output register handshake.
module aes_cbc_ctrl import aes_cbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_sts_t  sts,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] S_KLOAD = 3'd0;
	localparam logic [2:0] S_KEXP  = 3'd1;
	localparam logic [2:0] S_IDLE  = 3'd2;
	localparam logic [2:0] S_RUN   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [3:0] cnt_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.kx_load = (state_q == S_KLOAD);
		cmd.kx_step = (state_q == S_KEXP);
		cmd.blk_load = (state_q == S_IDLE) && in_valid;
		cmd.rnd_en = (state_q == S_RUN);
		cmd.cnt = (state_q == S_IDLE) ? 4'd0 : cnt_q;
		cmd.out_load = (state_q == S_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_KLOAD;
			cnt_q <= 4'd0;
		end else if (sts.key_wr) begin
			state_q <= S_KLOAD;
		end else begin
			case (state_q)
				S_KLOAD: begin
					cnt_q <= 4'd2;
					state_q <= S_KEXP;
				end
				S_KEXP: begin
					if (cnt_q == 4'(LAST_ROUND)) state_q <= S_IDLE;
					else cnt_q <= cnt_q + 4'd1;
				end
				S_IDLE: begin
					if (in_valid) begin
						cnt_q <= 4'd1;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (cnt_q == 4'(LAST_ROUND)) state_q <= S_DONE;
					else cnt_q <= cnt_q + 4'd1;
				end
				S_DONE: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_KLOAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_run_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (cnt_q >= 4'd1 && cnt_q <= 4'(LAST_ROUND)))
		else $error("round count out of range");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && !sts.key_wr) |=> (state_q == S_RUN && cnt_q == 4'd1))
		else $error("accepted transaction did not start rounds");

	a_rekey: assert property (@(posedge clk) disable iff (!arst_n)
		sts.key_wr |=> (state_q == S_KLOAD))
		else $error("key write did not restart expansion");

endmodule

### hdl/aes_cbc_dp.sv
// Datapath: config registers, round key store, AES round unit, CBC chain and pad logic.
module aes_cbc_dp import aes_cbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        first_block,
	input  logic        last_block,
	input  logic [4:0]  valid_bytes,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic        out_last,
	output logic        pad_removed,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts
);

	logic [63:0]  key_q [4];
	logic [127:0] iv_q;
	logic         dec_q;
	logic [127:0] rk_q [NUM_RK];
	logic [255:0] kx_q;
	logic [127:0] st_q;
	logic [127:0] chain_q;
	logic [127:0] xv_q;
	logic         last_q;
	logic [127:0] res_q;
	logic         olast_q;
	logic         pad_q;

	logic [3:0]   rk_addr;
	logic [127:0] rk;
	logic [127:0] kx_new;
	logic [127:0] blk;
	logic [127:0] xin;
	logic [127:0] padded;
	logic [127:0] enc_r;
	logic [127:0] enc_n;
	logic [127:0] dec_r;
	logic [127:0] dec_n;
	logic [127:0] plain;
	logic [127:0] fin;
	logic         pad_ok;
	logic [7:0]   npad;

	assign sts.key_wr = cfg_we && (cfg_idx <= REG_KEY3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= 64'h0;
			iv_q <= 128'h0;
			dec_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KEY0: key_q[0] <= cfg_data;
				REG_KEY1: key_q[1] <= cfg_data;
				REG_KEY2: key_q[2] <= cfg_data;
				REG_KEY3: key_q[3] <= cfg_data;
				REG_IV_HI: iv_q[127:64] <= cfg_data;
				REG_IV_LO: iv_q[63:0] <= cfg_data;
				REG_DEC: dec_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key expansion, one round key per cycle
	assign kx_new = kx_next(kx_q, cmd.cnt);

	always_ff @(posedge clk) begin
		if (cmd.kx_load) begin
			kx_q <= {key_q[0], key_q[1], key_q[2], key_q[3]};
			rk_q[0] <= {key_q[0], key_q[1]};
			rk_q[1] <= {key_q[2], key_q[3]};
		end else if (cmd.kx_step) begin
			kx_q <= {kx_q[127:0], kx_new};
			rk_q[cmd.cnt] <= kx_new;
		end
	end

	// decrypt walks the schedule from the top
	assign rk_addr = dec_q ? (4'(LAST_ROUND) - cmd.cnt) : cmd.cnt;
	assign rk = rk_q[rk_addr];

	assign blk = {block_high, block_low};
	assign xin = first_block ? iv_q : chain_q;

	always_comb begin
		padded = blk;
		if (last_block && valid_bytes >= 5'd1 && valid_bytes <= 5'd15) begin
			for (int i = 0; i < BLK_BYTES; i++) begin
				if (5'(i) >= valid_bytes) padded[127-8*i -: 8] = 8'(5'd16 - valid_bytes);
			end
		end
	end

	always_comb begin
		enc_r = shift_rows(sub_bytes(st_q, 1'b0), 1'b0);
		enc_n = ((cmd.cnt == 4'(LAST_ROUND)) ? enc_r : mix_cols(enc_r, 1'b0)) ^ rk;
		dec_r = sub_bytes(shift_rows(st_q, 1'b1), 1'b1) ^ rk;
		dec_n = (cmd.cnt == 4'(LAST_ROUND)) ? dec_r : mix_cols(dec_r, 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			xv_q <= 128'h0;
			st_q <= 128'h0;
			chain_q <= 128'h0;
		end else begin
			if (cmd.blk_load) begin
				last_q <= last_block;
				xv_q <= xin;
				if (dec_q) begin
					st_q <= blk ^ rk;
					chain_q <= blk;
				end else begin
					st_q <= padded ^ xin ^ rk;
				end
			end else if (cmd.rnd_en) begin
				st_q <= dec_q ? dec_n : enc_n;
			end
			if (cmd.out_load && !dec_q) chain_q <= st_q;
		end
	end

	// pad check on the recovered plaintext
	always_comb begin
		plain = st_q ^ xv_q;
		npad = plain[7:0];
		pad_ok = last_q && npad >= 8'd1 && npad <= 8'd16;
		for (int i = 0; i < BLK_BYTES; i++) begin
			if (8'(i) >= 8'd16 - npad && plain[127-8*i -: 8] != npad) pad_ok = 1'b0;
		end
		fin = plain;
		if (pad_ok) begin
			for (int i = 0; i < BLK_BYTES; i++) begin
				if (8'(i) >= 8'd16 - npad) fin[127-8*i -: 8] = 8'h00;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= dec_q ? fin : st_q;
			olast_q <= last_q;
			pad_q <= dec_q && pad_ok;
		end
	end

	assign out_high = res_q[127:64];
	assign out_low = res_q[63:0];
	assign out_last = olast_q;
	assign pad_removed = pad_q;

endmodule
